// ===== src/bsfns_pkg.sv =====
// ----------------------------------------------------------------------------
// bsfns_pkg
// Shared sizes, request codes and controller states for the bitmap store
// with find-next-set.
// ----------------------------------------------------------------------------
package bsfns_pkg;

  localparam int TOTAL_BITS = 1024;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam int POS_W   = $clog2(TOTAL_BITS);
  localparam int CNT_W   = $clog2(TOTAL_BITS + 1);
  localparam int BIT_IW  = $clog2(WORD_BITS);
  localparam int WORD_AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int MODE_W  = 3;

  localparam logic [MODE_W-1:0] MODE_SET       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TEST      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ANY       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SCAN
  } st_t;

endpackage

// ===== src/bitmap_store_find_next_set_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_store_find_next_set_unit
// Bitmap of up to TOTAL_BITS bits in a word memory with set, clear, test,
// find-next-set, any and clear-all requests.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  in_       start / busy       in_mode, in_bit_pos
//  out_      out_strobe         out_bit_value, out_found, out_found_pos,
//                               out_bad_pos
//  cfg_      cfg_we             cfg_wdata (active bit count)
//
//  Bad position, any with no bits in use, clear all and unused modes: result
//  in the cycle after start, busy stays low.
//  Set, clear, test: word read, then write back (set and clear only).
//  Find and any: one memory word is read per cycle, from the word of in_bit_pos
//  (find) or word 0 (any) up to the last word in use; the scan stops at a hit.
//  Reset clears the per-word valid flags at once; no clearing pass.
//  The receiver cannot stall: each result is on the ports for one cycle.
// ----------------------------------------------------------------------------
module bitmap_store_find_next_set_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [bsfns_pkg::MODE_W-1:0] in_mode,
  input  logic [bsfns_pkg::POS_W-1:0]  in_bit_pos,
  output logic                         out_strobe,
  output logic                         out_bit_value,
  output logic                         out_found,
  output logic [bsfns_pkg::POS_W-1:0]  out_found_pos,
  output logic                         out_bad_pos,
  input  logic                         cfg_we,
  input  logic [bsfns_pkg::CNT_W-1:0]  cfg_wdata
);

  localparam int WB = bsfns_pkg::WORD_BITS;
  localparam int AW = bsfns_pkg::WORD_AW;
  localparam int IW = bsfns_pkg::BIT_IW;
  localparam int PW = bsfns_pkg::POS_W;
  localparam int CW = bsfns_pkg::CNT_W;
  localparam int NW = bsfns_pkg::NUM_WORDS;

  bsfns_pkg::st_t                state_r, state_nxt;
  logic [bsfns_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [CW-1:0]                 n_r, n_nxt;
  logic [AW-1:0]                 last_r, last_nxt;
  logic [AW-1:0]                 addr_r, addr_nxt;
  logic                          first_r, first_nxt;
  logic [NW-1:0]                 vld_r, vld_nxt;
  logic [CW-1:0]                 active_bits_r;

  logic                          out_strobe_r, out_strobe_nxt;
  logic                          out_bit_value_r, out_bit_value_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [PW-1:0]                 out_found_pos_r, out_found_pos_nxt;
  logic                          out_bad_pos_r, out_bad_pos_nxt;

  logic [WB-1:0]                 mem [NW];
  logic [WB-1:0]                 rdata_r;
  logic [AW-1:0]                 rd_addr;
  logic                          mem_we;
  logic [WB-1:0]                 mem_wdata;

  logic [CW-1:0]                 n_cur;
  logic [CW-1:0]                 n_m1;
  logic                          in_bad;
  logic [AW-1:0]                 in_word;
  logic [WB-1:0]                 word_d;
  logic [IW-1:0]                 lo_bit;
  logic [WB-1:0]                 lo_mask;
  logic [WB-1:0]                 hi_mask;
  logic [WB-1:0]                 cand;
  logic [WB-1:0]                 bit_mask;
  logic                          hit;
  logic [IW-1:0]                 hit_idx;

  assign busy          = (state_r != bsfns_pkg::ST_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_bit_value = out_bit_value_r;
  assign out_found     = out_found_r;
  assign out_found_pos = out_found_pos_r;
  assign out_bad_pos   = out_bad_pos_r;

  assign n_cur   = (active_bits_r > CW'(bsfns_pkg::TOTAL_BITS)) ?
                   CW'(bsfns_pkg::TOTAL_BITS) : active_bits_r;
  assign n_m1    = n_cur - CW'(1);
  assign in_bad  = (in_mode <= bsfns_pkg::MODE_FIND) && ({1'b0, in_bit_pos} >= n_cur);
  assign in_word = in_bit_pos[IW+AW-1:IW];

  assign word_d   = vld_r[addr_r] ? rdata_r : '0;
  assign lo_bit   = (first_r && (mode_r == bsfns_pkg::MODE_FIND)) ? pos_r[IW-1:0] : '0;
  assign lo_mask  = {WB{1'b1}} << lo_bit;
  assign hi_mask  = ((addr_r == last_r) && (n_r[IW-1:0] != '0)) ?
                    ~({WB{1'b1}} << n_r[IW-1:0]) : {WB{1'b1}};
  assign cand     = word_d & lo_mask & hi_mask;
  assign hit      = |cand;
  assign bit_mask = {{(WB-1){1'b0}}, 1'b1} << pos_r[IW-1:0];

  always_comb begin
    hit_idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bsfns_pkg::ST_IDLE;
      vld_r         <= '0;
      active_bits_r <= CW'(bsfns_pkg::TOTAL_BITS);
      out_strobe_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        active_bits_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r          <= mode_nxt;
    pos_r           <= pos_nxt;
    n_r             <= n_nxt;
    last_r          <= last_nxt;
    addr_r          <= addr_nxt;
    first_r         <= first_nxt;
    out_bit_value_r <= out_bit_value_nxt;
    out_found_r     <= out_found_nxt;
    out_found_pos_r <= out_found_pos_nxt;
    out_bad_pos_r   <= out_bad_pos_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    mode_nxt          = mode_r;
    pos_nxt           = pos_r;
    n_nxt             = n_r;
    last_nxt          = last_r;
    addr_nxt          = addr_r;
    first_nxt         = first_r;
    vld_nxt           = vld_r;
    rd_addr           = addr_r;
    mem_we            = 1'b0;
    mem_wdata         = (mode_r == bsfns_pkg::MODE_SET) ? (word_d | bit_mask) :
                                                          (word_d & ~bit_mask);
    out_strobe_nxt    = 1'b0;
    out_bit_value_nxt = 1'b0;
    out_found_nxt     = 1'b0;
    out_found_pos_nxt = '0;
    out_bad_pos_nxt   = 1'b0;

    unique case (state_r)
      bsfns_pkg::ST_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          pos_nxt   = in_bit_pos;
          n_nxt     = n_cur;
          last_nxt  = n_m1[IW+AW-1:IW];
          first_nxt = 1'b1;
          if (in_bad) begin
            out_strobe_nxt  = 1'b1;
            out_bad_pos_nxt = 1'b1;
          end else begin
            unique case (in_mode) inside
              bsfns_pkg::MODE_SET, bsfns_pkg::MODE_CLEAR, bsfns_pkg::MODE_TEST: begin
                rd_addr   = in_word;
                addr_nxt  = in_word;
                state_nxt = bsfns_pkg::ST_RMW;
              end
              bsfns_pkg::MODE_FIND: begin
                rd_addr   = in_word;
                addr_nxt  = in_word;
                state_nxt = bsfns_pkg::ST_SCAN;
              end
              bsfns_pkg::MODE_ANY: begin
                if (n_cur == '0) begin
                  out_strobe_nxt = 1'b1;
                end else begin
                  rd_addr   = '0;
                  addr_nxt  = '0;
                  state_nxt = bsfns_pkg::ST_SCAN;
                end
              end
              bsfns_pkg::MODE_CLEAR_ALL: begin
                vld_nxt        = '0;
                out_strobe_nxt = 1'b1;
              end
              default: begin
                out_strobe_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      bsfns_pkg::ST_RMW: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = bsfns_pkg::ST_IDLE;
        if (mode_r == bsfns_pkg::MODE_TEST) begin
          out_bit_value_nxt = word_d[pos_r[IW-1:0]];
        end else begin
          mem_we          = 1'b1;
          vld_nxt[addr_r] = 1'b1;
        end
      end
      bsfns_pkg::ST_SCAN: begin
        first_nxt = 1'b0;
        if (hit) begin
          out_strobe_nxt = 1'b1;
          out_found_nxt  = 1'b1;
          if (mode_r == bsfns_pkg::MODE_FIND) begin
            out_found_pos_nxt = {addr_r, hit_idx};
          end
          state_nxt = bsfns_pkg::ST_IDLE;
        end else if (addr_r == last_r) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = bsfns_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
          rd_addr  = addr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = bsfns_pkg::ST_IDLE;
      end
    endcase
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while a request is still in progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bsfns_pkg::ST_SCAN) |-> (addr_r <= last_r))
    else $error("scan ran past the last word in use");

  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bad_pos) |->
      (!out_found && !out_bit_value && (out_found_pos == '0)))
    else $error("bad position result carries data");

  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted request neither answered nor in progress");

endmodule
